@@ hdl/wsteer_pkg.sv @@
package wsteer_pkg;

   localparam int CORDIC_ITERATIONS = 16;
   localparam int ATAN_LEN          = 24;
   localparam int ATAN_IDX_W        = $clog2(ATAN_LEN);
   localparam int ITER_W            = $clog2(CORDIC_ITERATIONS + 1);

   localparam int POS_W  = 17;
   localparam int ANG_W  = 17;
   localparam int IDX_W  = 5;
   localparam int SW_W   = 8;
   localparam int MS_W   = 6;
   localparam int SPD_W  = 8;

   // Offset to the target, CORDIC vector, angle accumulator and error widths.
   localparam int DIF_W  = 19;
   localparam int CV_W   = 30;
   localparam int Z_W    = 34;
   localparam int ERR_W  = 19;
   localparam int DEL_W  = 20;
   localparam int PROD_W = DEL_W + MS_W;

   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 8;

   localparam logic signed [Z_W-1:0]   PI_Q29      = 34'sd1686629713;
   localparam logic signed [ERR_W-1:0] PI_Q13      = 19'sd25736;
   localparam logic signed [ERR_W-1:0] TWO_PI_Q13  = 19'sd51472;
   localparam logic signed [ERR_W-1:0] ENTER_SPIN  = 19'sd9830;
   localparam logic signed [ERR_W-1:0] LEAVE_SPIN  = 19'sd245;
   localparam logic [10:0]             ARRIVE_SQ   = 11'd576;
   localparam logic [4:0]              ARRIVE_AXIS = 5'd24;

   localparam logic [SW_W-1:0] SECTOR_WIDTH_RST = 8'd60;
   localparam logic [MS_W-1:0] MEDIUM_SPEED_RST = 6'd20;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SECTOR_WIDTH = 4'd0,
      CSR_MEDIUM_SPEED = 4'd1
   } csr_idx_type;

   // Elementary angles atan(2^-i) in radians with 29 fraction bits.
   function automatic logic [29:0] atan_q29(input logic [ATAN_IDX_W-1:0] i);
      case (i)
         5'd0:    atan_q29 = 30'd421657428;
         5'd1:    atan_q29 = 30'd248918915;
         5'd2:    atan_q29 = 30'd131521918;
         5'd3:    atan_q29 = 30'd66762579;
         5'd4:    atan_q29 = 30'd33510843;
         5'd5:    atan_q29 = 30'd16771758;
         5'd6:    atan_q29 = 30'd8387925;
         5'd7:    atan_q29 = 30'd4194219;
         5'd8:    atan_q29 = 30'd2097141;
         5'd9:    atan_q29 = 30'd1048575;
         5'd10:   atan_q29 = 30'd524288;
         5'd11:   atan_q29 = 30'd262144;
         5'd12:   atan_q29 = 30'd131072;
         5'd13:   atan_q29 = 30'd65536;
         5'd14:   atan_q29 = 30'd32768;
         5'd15:   atan_q29 = 30'd16384;
         5'd16:   atan_q29 = 30'd8192;
         5'd17:   atan_q29 = 30'd4096;
         5'd18:   atan_q29 = 30'd2048;
         5'd19:   atan_q29 = 30'd1024;
         5'd20:   atan_q29 = 30'd512;
         5'd21:   atan_q29 = 30'd256;
         5'd22:   atan_q29 = 30'd128;
         5'd23:   atan_q29 = 30'd64;
         default: atan_q29 = 30'd0;
      endcase
   endfunction

endpackage

@@ hdl/wsteer_ifs.sv @@
interface wsteer_req_if;
   import wsteer_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic signed [ANG_W-1:0] heading;
   logic signed [IDX_W-1:0] target_col;
   logic signed [IDX_W-1:0] target_row;
   modport source (output valid, pos_x, pos_y, heading, target_col, target_row, input ready);
   modport sink (input valid, pos_x, pos_y, heading, target_col, target_row, output ready);
endinterface

interface wsteer_rsp_if;
   import wsteer_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [SPD_W-1:0] left_speed;
   logic signed [SPD_W-1:0] right_speed;
   logic                    arrived;
   logic                    spinning;
   modport source (output valid, left_speed, right_speed, arrived, spinning, input ready);
   modport sink (input valid, left_speed, right_speed, arrived, spinning, output ready);
endinterface

interface wsteer_csr_if;
   import wsteer_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] idx;
   logic [CSR_DAT_W-1:0] wdata;
   modport source (output valid, idx, wdata, input ready);
   modport sink (input valid, idx, wdata, output ready);
endinterface

@@ hdl/wsteer_cordic.sv @@
module wsteer_cordic (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [wsteer_pkg::DIF_W-1:0] yv,
   input  logic signed [wsteer_pkg::DIF_W-1:0] xv,
   output logic                               done,
   output logic signed [wsteer_pkg::ERR_W-1:0] angle
);
   import wsteer_pkg::*;

   logic signed [CV_W-1:0]  x_ff, x_in, y_ff, y_in, x0, y0, xs, ys;
   logic signed [Z_W-1:0]   z_ff, z_in, zr, zstep;
   logic [ITER_W-1:0]       cnt_ff, cnt_in;
   logic                    busy_ff, busy_in, done_ff, done_in;

   // Operands are scaled by 256 before vectoring.
   assign x0 = {{(CV_W-DIF_W-8){xv[DIF_W-1]}}, xv, 8'd0};
   assign y0 = {{(CV_W-DIF_W-8){yv[DIF_W-1]}}, yv, 8'd0};
   assign xs = x_ff >>> cnt_ff;
   assign ys = y_ff >>> cnt_ff;
   assign zstep = Z_W'(signed'({1'b0, atan_q29(ATAN_IDX_W'(cnt_ff))}));
   assign zr    = z_ff + Z_W'(32768);

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         cnt_in  = '0;
         busy_in = 1'b1;
         if (x0 < 0) begin
            // Left half plane: fold by pi and rotate the vector half a turn.
            x_in = -x0;
            y_in = -y0;
            z_in = (y0 >= 0) ? PI_Q29 : -PI_Q29;
         end else begin
            x_in = x0;
            y_in = y0;
            z_in = '0;
         end
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + zstep;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - zstep;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ITER_W'(CORDIC_ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // The rounded angle is taken from the accumulator as done rises.
   assign done  = done_ff;
   assign angle = ERR_W'(zr >>> 16);
endmodule

@@ hdl/wsteer_smul.sv @@
module wsteer_smul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [wsteer_pkg::DEL_W-1:0]  a,
   input  logic [wsteer_pkg::MS_W-1:0]          b,
   output logic                                done,
   output logic signed [wsteer_pkg::PROD_W-1:0] prod
);
   import wsteer_pkg::*;

   localparam int CNT_W = $clog2(MS_W + 1);

   logic signed [PROD_W-1:0] acc_ff, acc_in, a_ff, a_in;
   logic [MS_W-1:0]          b_ff, b_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     busy_ff, busy_in, done_ff, done_in;

   // One multiplier bit per cycle, least significant first.
   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = PROD_W'(a);
         b_in    = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in   = a_ff <<< 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(MS_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

@@ hdl/waypoint_heading_steering.sv @@
// Flow: a transferred request passes the calculate and check states; an item inside the arrival radius
// then goes to the result, any other runs the CORDIC, the wrap steps and the speed multiplier first.
// Throughput: one item at a time; the iterative CORDIC and the bit-serial speed multiplier
// set the figure. A new request is taken once the previous result sits in the output register.
// Reset is synchronous and active high: sector width 60, medium speed 20, drive mode.
module waypoint_heading_steering (
   input logic         clock,
   input logic         reset,
   wsteer_req_if.sink   req_chan,
   wsteer_rsp_if.source rsp_chan,
   wsteer_csr_if.sink   csr_chan
);
   import wsteer_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_CALC = 7'b0000010,
      ST_CHK  = 7'b0000100,
      ST_CORD = 7'b0001000,
      ST_WRAP = 7'b0010000,
      ST_MULT = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [SW_W-1:0] sw_ff, sw_in;
   logic [MS_W-1:0] ms_ff, ms_in;

   // Latched request fields.
   logic signed [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [ANG_W-1:0] hd_ff, hd_in;
   logic signed [IDX_W-1:0] col_ff, col_in, row_ff, row_in;

   // Working values.
   logic signed [DIF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [ERR_W-1:0] err_ff, err_in;
   logic                    mode_ff, mode_in, mode_nx_ff, mode_nx_in;
   logic signed [SPD_W-1:0] spin_ff, spin_in;

   // Result held until the output register is free.
   logic signed [SPD_W-1:0] res_l_ff, res_l_in, res_r_ff, res_r_in;
   logic                    res_arr_ff, res_arr_in, res_spin_ff, res_spin_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SPD_W-1:0] rsp_l_ff, rsp_l_in, rsp_r_ff, rsp_r_in;
   logic                    rsp_arr_ff, rsp_arr_in, rsp_spin_ff, rsp_spin_in;

   logic                    cord_start, cord_done, mul_start, mul_done;
   logic signed [ERR_W-1:0] cord_angle;
   logic signed [PROD_W-1:0] mul_prod;

   logic signed [13:0]      col_sw, row_sw;
   logic signed [DIF_W-1:0] tgt_x, tgt_y, adx, ady;
   logic [10:0]             dist_sq;
   logic                    near;
   logic signed [ERR_W-1:0] mag;
   logic [ERR_W+5:0]        m35;
   logic [SPD_W-1:0]        spin_abs;
   logic signed [DEL_W-1:0] err6;
   logic signed [PROD_W:0]  base, q_l, q_r;
   logic                    req_fire, out_free;

   // Saturated truncating division of a drive sum by 40960. The magnitude is first
   // shifted by 13, and the remaining division by five is a reciprocal multiply that
   // is exact over the range left before saturation.
   function automatic logic signed [SPD_W-1:0] drive_cmd(input logic signed [PROD_W:0] q);
      logic [PROD_W:0]       aq;
      logic [PROD_W-13:0]    n;
      logic [PROD_W+1:0]     t;
      logic [SPD_W-1:0]      v;
      aq = (q < 0) ? unsigned'(-q) : unsigned'(q);
      n  = aq[PROD_W:13];
      t  = (PROD_W+2)'(n) * (PROD_W+2)'(13108);
      if (n >= (PROD_W-12)'(635)) begin
         v = 8'd127;
      end else begin
         v = SPD_W'(t >> 16);
      end
      drive_cmd = (q < 0) ? -signed'(v) : signed'(v);
   endfunction

   assign req_fire = req_chan.valid && req_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Target corner in Q.4 and the offset from the current position.
   assign col_sw = 14'(col_ff) * signed'(14'({1'b0, sw_ff}));
   assign row_sw = 14'(row_ff) * signed'(14'({1'b0, sw_ff}));
   assign tgt_x  = DIF_W'(col_sw) <<< 4;
   assign tgt_y  = DIF_W'(row_sw) <<< 4;

   // Arrival test: each axis within 24 sixteenths before the small squares are summed.
   assign adx     = (dx_ff < 0) ? -dx_ff : dx_ff;
   assign ady     = (dy_ff < 0) ? -dy_ff : dy_ff;
   assign near    = (adx <= DIF_W'(ARRIVE_AXIS)) && (ady <= DIF_W'(ARRIVE_AXIS));
   assign dist_sq = 11'(adx[4:0]) * 11'(adx[4:0]) + 11'(ady[4:0]) * 11'(ady[4:0]);

   // Spin band: |err|*35 against one and sixteen whole steps of 8192.
   assign mag      = (err_ff < 0) ? -err_ff : err_ff;
   assign m35      = (ERR_W+6)'(unsigned'(mag)) * (ERR_W+6)'(35);
   assign spin_abs = (m35 < (ERR_W+6)'(8192))   ? 8'd0 :
                     (m35 < (ERR_W+6)'(131072)) ? 8'd8 : 8'd15;
   assign err6     = (DEL_W'(err_ff) <<< 2) + (DEL_W'(err_ff) <<< 1);

   // Drive sums: medium*8192*5 plus or minus medium*err*6.
   assign base = (PROD_W+1)'(unsigned'(ms_ff)) * (PROD_W+1)'(40960);
   assign q_l  = base + (PROD_W+1)'(mul_prod);
   assign q_r  = base - (PROD_W+1)'(mul_prod);

   always_comb begin
      state_in    = state_ff;
      sw_in       = sw_ff;
      ms_in       = ms_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      hd_in       = hd_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      err_in      = err_ff;
      mode_in     = mode_ff;
      mode_nx_in  = mode_nx_ff;
      spin_in     = spin_ff;
      res_l_in    = res_l_ff;
      res_r_in    = res_r_ff;
      res_arr_in  = res_arr_ff;
      res_spin_in = res_spin_ff;
      rsp_l_in    = rsp_l_ff;
      rsp_r_in    = rsp_r_ff;
      rsp_arr_in  = rsp_arr_ff;
      rsp_spin_in = rsp_spin_ff;
      rsp_valid_in = rsp_valid_ff;
      cord_start  = 1'b0;
      mul_start   = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_chan.valid) begin
         if (csr_chan.idx == CSR_SECTOR_WIDTH) begin
            sw_in = csr_chan.wdata;
         end else if (csr_chan.idx == CSR_MEDIUM_SPEED) begin
            ms_in = csr_chan.wdata[MS_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               px_in    = req_chan.pos_x;
               py_in    = req_chan.pos_y;
               hd_in    = req_chan.heading;
               col_in   = req_chan.target_col;
               row_in   = req_chan.target_row;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            dx_in    = tgt_x - DIF_W'(px_ff);
            dy_in    = tgt_y - DIF_W'(py_ff);
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (near && (dist_sq <= ARRIVE_SQ)) begin
               // At the target: motors stop and the turn-in-place flag drops.
               res_l_in    = '0;
               res_r_in    = '0;
               res_arr_in  = 1'b1;
               res_spin_in = 1'b0;
               mode_nx_in  = 1'b0;
               state_in    = ST_DONE;
            end else begin
               cord_start = 1'b1;
               state_in   = ST_CORD;
            end
         end
         ST_CORD: begin
            if (cord_done) begin
               err_in   = cord_angle - ERR_W'(hd_ff);
               state_in = ST_WRAP;
            end
         end
         ST_WRAP: begin
            // One turn is added or removed per cycle until the error lies in (-pi, pi].
            if (err_ff > PI_Q13) begin
               err_in = err_ff - TWO_PI_Q13;
            end else if (err_ff <= -PI_Q13) begin
               err_in = err_ff + TWO_PI_Q13;
            end else begin
               mode_nx_in = mode_ff ? !(mag <= LEAVE_SPIN) : (mag > ENTER_SPIN);
               spin_in    = (err_ff < 0) ? -signed'(spin_abs) : signed'(spin_abs);
               mul_start  = 1'b1;
               state_in   = ST_MULT;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               res_arr_in  = 1'b0;
               res_spin_in = mode_nx_ff;
               if (mode_nx_ff) begin
                  res_l_in = spin_ff;
                  res_r_in = -spin_ff;
               end else begin
                  res_l_in = drive_cmd(q_l);
                  res_r_in = drive_cmd(q_r);
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               rsp_arr_in   = res_arr_ff;
               rsp_spin_in  = res_spin_ff;
               rsp_valid_in = 1'b1;
               mode_in      = mode_nx_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      hd_ff       <= hd_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      err_ff      <= err_in;
      mode_nx_ff  <= mode_nx_in;
      spin_ff     <= spin_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      res_arr_ff  <= res_arr_in;
      res_spin_ff <= res_spin_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_arr_ff  <= rsp_arr_in;
      rsp_spin_ff <= rsp_spin_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         sw_ff        <= SECTOR_WIDTH_RST;
         ms_ff        <= MEDIUM_SPEED_RST;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sw_ff        <= sw_in;
         ms_ff        <= ms_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Bearing to the target: atan2(dx, dy).
   wsteer_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cord_start),
      .yv    (dx_ff),
      .xv    (dy_ff),
      .done  (cord_done),
      .angle (cord_angle)
   );

   // Medium speed times six times the error, one bit of speed per cycle.
   wsteer_smul u_smul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (err6),
      .b     (ms_ff),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign csr_chan.ready       = 1'b1;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.left_speed  = rsp_l_ff;
   assign rsp_chan.right_speed = rsp_r_ff;
   assign rsp_chan.arrived     = rsp_arr_ff;
   assign rsp_chan.spinning    = rsp_spin_ff;

   // An arrival result always carries stopped motors and drive mode.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.arrived |->
         rsp_chan.left_speed == 0 && rsp_chan.right_speed == 0 && !rsp_chan.spinning)
      else $error("arrival result with motors running");

   // Turning in place drives the wheels in opposite directions by equal amounts.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.spinning |-> rsp_chan.left_speed == -rsp_chan.right_speed)
      else $error("spin command not symmetric");

   // The turn-in-place flag only changes when a result is loaded into the output register.
   assert property (@(posedge clock) disable iff (reset)
      mode_ff != $past(mode_ff) |-> $rose(rsp_valid_ff) || (rsp_valid_ff && $past(rsp_chan.ready)))
      else $error("turn mode changed outside result hand-over");
endmodule

@@ bench/waypoint_heading_steering_tb.sv @@
module waypoint_heading_steering_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsteer_pkg::*;

   // The run is ended by force well past the slowest legal completion time.
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 60;
   localparam int PHASE_ITEMS   = 290;
   localparam int LONG_HOLD     = 400;

   typedef struct {
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [ANG_W-1:0] heading;
      logic signed [IDX_W-1:0] target_col;
      logic signed [IDX_W-1:0] target_row;
   } pose_type;

   typedef struct {
      logic signed [SPD_W-1:0] left_speed;
      logic signed [SPD_W-1:0] right_speed;
      logic                    arrived;
      logic                    spinning;
   } motor_cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wsteer_req_if req_bus ();
   wsteer_rsp_if rsp_bus ();
   wsteer_csr_if csr_bus ();

   waypoint_heading_steering uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #2 clock = ~clock;

   // Poses waiting to be offered, and the motor commands the block owes us.
   pose_type      pose_q[$];
   motor_cmd_type cmd_q[$];

   // Our own copy of the block's registers and of its turn-in-place flag.
   logic [SW_W-1:0] sector_width_m = SECTOR_WIDTH_RST;
   logic [MS_W-1:0] medium_speed_m = MEDIUM_SPEED_RST;
   bit              turning_m      = 1'b0;

   int  fail_count = 0;
   int  mismatch_count = 0;
   int  sent_count = 0;
   int  cmd_count = 0;
   int  spin_count = 0;
   int  arrive_count = 0;
   longint cycle_count = 0;

   // Long receiver hold-off, started from the stimulus process and timed here.
   logic stall_kick = 1'b0;
   int   stall_left = 0;

   // Elementary angles atan(2^-i), radians with 29 fraction bits.
   longint atan_lut[24] = '{
      421657428, 248918915, 131521918, 66762579, 33510843,
      16771758, 8387925, 4194219, 2097141, 1048575, 524288,
      262144, 131072, 65536, 32768, 16384, 8192, 4096,
      2048, 1024, 512, 256, 128, 64};

   // Vectoring CORDIC giving the bearing of (east, north) in Q3.13 radians.
   function automatic longint bearing_q13(input longint east, input longint north);
      longint vx, vy, z, old_x;
      vx = north * 256;
      vy = east * 256;
      z  = 0;
      if (vx < 0) begin
         z  = (vy >= 0) ? 64'sd1686629713 : -64'sd1686629713;
         vx = -vx;
         vy = -vy;
      end
      for (int i = 0; i < CORDIC_ITERATIONS && i < 24; i++) begin
         old_x = vx;
         if (vy > 0) begin
            vx = vx + (vy >>> i);
            vy = vy - (old_x >>> i);
            z  = z + atan_lut[i];
         end else begin
            vx = vx - (vy >>> i);
            vy = vy + (old_x >>> i);
            z  = z - atan_lut[i];
         end
      end
      return (z + 32768) >>> 16;
   endfunction

   function automatic longint clip127(input longint v);
      if (v > 127) return 127;
      if (v < -127) return -127;
      return v;
   endfunction

   // Works out the command for one pose and advances the turn-in-place flag.
   function automatic motor_cmd_type steer_for(input pose_type p);
      motor_cmd_type c;
      longint sw, ms, dx, dy, err, mag, s, base, delta;
      sw = longint'(sector_width_m);
      ms = longint'(medium_speed_m);
      dx = longint'(p.target_col) * sw * 16 - longint'(p.pos_x);
      dy = longint'(p.target_row) * sw * 16 - longint'(p.pos_y);
      c.arrived = 1'b0;
      if (dx * dx + dy * dy <= 576) begin
         turning_m     = 1'b0;
         c.left_speed  = '0;
         c.right_speed = '0;
         c.arrived     = 1'b1;
         c.spinning    = 1'b0;
         return c;
      end
      err = bearing_q13(dx, dy) - longint'(p.heading);
      while (err > 25736) err -= 51472;
      while (err <= -25736) err += 51472;
      mag = (err < 0) ? -err : err;
      if (turning_m) begin
         if (mag <= 245) turning_m = 1'b0;
      end else if (mag > 9830) begin
         turning_m = 1'b1;
      end
      if (turning_m) begin
         s = (err * 35) / 8192;
         if (s < -15) s = -15;
         else if (s < 0) s = -8;
         else if (s > 15) s = 15;
         else if (s > 0) s = 8;
         c.left_speed  = s[SPD_W-1:0];
         c.right_speed = SPD_W'(-s);
      end else begin
         base  = ms * 8192 * 5;
         delta = ms * err * 6;
         c.left_speed  = SPD_W'(clip127((base + delta) / 40960));
         c.right_speed = SPD_W'(clip127((base - delta) / 40960));
      end
      c.spinning = turning_m;
      return c;
   endfunction

   // Idle lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   // Sender. A pose stays on the bus until it is taken; gaps fall only between transfers.
   int  send_gap = 0;
   bit  send_burst = 1'b0;

   always @(posedge clock) begin
      bit taken;
      if (reset) begin
         req_bus.valid      <= 1'b0;
         req_bus.pos_x      <= '0;
         req_bus.pos_y      <= '0;
         req_bus.heading    <= '0;
         req_bus.target_col <= '0;
         req_bus.target_row <= '0;
      end else begin
         taken = req_bus.valid && req_bus.ready;
         if (taken) begin
            cmd_q.push_back(steer_for(pose_q.pop_front()));
            sent_count++;
            if ($urandom_range(0, 99) == 0) send_burst = ~send_burst;
            send_gap = send_burst ? 0 : pick_gap();
         end
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pose_q.size() > 0) begin
               req_bus.valid      <= 1'b1;
               req_bus.pos_x      <= pose_q[0].pos_x;
               req_bus.pos_y      <= pose_q[0].pos_y;
               req_bus.heading    <= pose_q[0].heading;
               req_bus.target_col <= pose_q[0].target_col;
               req_bus.target_row <= pose_q[0].target_row;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) stall_left <= 0;
      else if (stall_kick) stall_left <= LONG_HOLD;
      else if (stall_left > 0) stall_left <= stall_left - 1;
   end

   // Receiver. Each result transfer is checked against the oldest command owed.
   int  recv_gap = 0;
   bit  recv_burst = 1'b0;

   always @(posedge clock) begin
      motor_cmd_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            cmd_count++;
            if (rsp_bus.spinning) spin_count++;
            if (rsp_bus.arrived) arrive_count++;
            if (cmd_q.size() == 0) begin
               fail_count++;
               $display("Unexpected result transfer at cycle %0d", cycle_count);
            end else begin
               want = cmd_q.pop_front();
               if (rsp_bus.left_speed !== want.left_speed ||
                   rsp_bus.right_speed !== want.right_speed ||
                   rsp_bus.arrived !== want.arrived ||
                   rsp_bus.spinning !== want.spinning) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch at cycle %0d: expected L=%0d R=%0d arr=%0b spin=%0b",
                              cycle_count, want.left_speed, want.right_speed,
                              want.arrived, want.spinning);
                     $display("   got L=%0d R=%0d arr=%0b spin=%0b",
                              rsp_bus.left_speed, rsp_bus.right_speed,
                              rsp_bus.arrived, rsp_bus.spinning);
                  end
               end
            end
            if ($urandom_range(0, 99) == 0) recv_burst = ~recv_burst;
            recv_gap = recv_burst ? 0 : pick_gap();
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Run timed out after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
      if (v > 65535) return 17'sd65535;
      if (v < -65536) return -17'sd65536;
      return v[POS_W-1:0];
   endfunction

   function automatic pose_type make_pose(input longint px, input longint py, input longint hd,
                                          input int col, input int row);
      pose_type p;
      p.pos_x      = clamp_pos(px);
      p.pos_y      = clamp_pos(py);
      p.heading    = hd[ANG_W-1:0];
      p.target_col = col[IDX_W-1:0];
      p.target_row = row[IDX_W-1:0];
      return p;
   endfunction

   function automatic int pick_index();
      int r;
      r = $urandom_range(0, 9);
      if (r < 7) return $urandom_range(0, 15);
      if (r < 8) return -1;
      return $signed($urandom_range(0, 31)) - 16;
   endfunction

   // Queues one approach towards a target: the robot closes in while its heading
   // drifts, so the error sweeps across both hysteresis thresholds.
   task automatic queue_approach(inout int budget);
      int      col, row, len, r;
      longint  ox, oy, hd, step, span, tx, ty;
      col  = pick_index();
      row  = pick_index();
      tx   = longint'(col) * longint'(sector_width_m) * 16;
      ty   = longint'(row) * longint'(sector_width_m) * 16;
      r    = $urandom_range(0, 2);
      span = (r == 0) ? 60 : (r == 1) ? 2000 : 40000;
      ox   = longint'($urandom_range(0, 2 * span)) - span;
      oy   = longint'($urandom_range(0, 2 * span)) - span;
      hd   = longint'($urandom_range(0, 102944)) - 51472;
      step = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 120) : $urandom_range(0, 3000);
      if ($urandom_range(0, 1) != 0) step = -step;
      len  = $urandom_range(4, 16);
      for (int k = 0; k < len && budget > 0; k++) begin
         pose_q.push_back(make_pose(tx + ox, ty + oy, hd, col, row));
         budget--;
         ox = (ox * 3) / 4;
         oy = (oy * 3) / 4;
         hd = hd + step;
         if (hd > 65535 || hd < -65536) hd = 0;
      end
   endtask

   task automatic queue_noise(inout int budget);
      pose_type p;
      p.pos_x      = POS_W'($urandom());
      p.pos_y      = POS_W'($urandom());
      p.heading    = ANG_W'($urandom());
      p.target_col = IDX_W'($urandom());
      p.target_row = IDX_W'($urandom());
      pose_q.push_back(p);
      budget--;
   endtask

   task automatic csr_write(input csr_idx_type idx, input logic [CSR_DAT_W-1:0] data);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.idx   <= idx;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      if (idx == CSR_SECTOR_WIDTH) sector_width_m = data;
      else medium_speed_m = data[MS_W-1:0];
   endtask

   // Waits until every command has come back, then lets the block settle.
   task automatic drain();
      wait (pose_q.size() == 0 && cmd_q.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int budget;
      int sw_list[5] = '{60, 1, 255, 0, 137};
      int ms_list[5] = '{20, 63, 0, 37, 1};
      csr_bus.valid = 1'b0;
      csr_bus.idx   = CSR_SECTOR_WIDTH;
      csr_bus.wdata = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed poses at the reset settings. The target at column one, row zero
      // lies due east at a bearing of about a quarter turn (12868).
      pose_q.push_back(make_pose(960, 0, 0, 1, 0));            // at the corner: arrived
      pose_q.push_back(make_pose(960 - 24, 0, 0, 1, 0));       // on the arrival radius
      pose_q.push_back(make_pose(960 - 25, 0, 0, 1, 0));       // just outside it
      pose_q.push_back(make_pose(0, 0, 0, 1, 0));              // large error: enter spin
      pose_q.push_back(make_pose(0, 0, 12868 - 5000, 1, 0));   // stay, strong band
      pose_q.push_back(make_pose(0, 0, 12868 - 1000, 1, 0));   // stay, weak band
      pose_q.push_back(make_pose(0, 0, 12868 - 100, 1, 0));    // small error: leave spin
      pose_q.push_back(make_pose(0, 0, 12868 - 5000, 1, 0));   // drive, no re-entry
      pose_q.push_back(make_pose(0, 0, 12868 + 11000, 1, 0));  // negative: enter spin
      pose_q.push_back(make_pose(0, 0, 12868 + 500, 1, 0));    // negative weak band
      pose_q.push_back(make_pose(0, 0, 12868 + 300, 1, 0));
      pose_q.push_back(make_pose(0, 0, 12868 - 240, 1, 0));    // leave at the edge
      pose_q.push_back(make_pose(65535, 65535, 51472, -16, -16));
      pose_q.push_back(make_pose(-65536, -65536, -51472, 15, 15));
      pose_q.push_back(make_pose(-65536, 65535, -65536, -1, 15));
      pose_q.push_back(make_pose(65535, -65536, 65535, 15, -1));
      pose_q.push_back(make_pose(0, -5000, 25736, 0, 0));      // target straight behind
      pose_q.push_back(make_pose(0, 5000, -25736, 0, 0));
      pose_q.push_back(make_pose(-5000, 0, 0, 0, 0));
      pose_q.push_back(make_pose(17, -13, 0, 0, 0));           // arrived from spin mode
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         if (ph > 0) begin
            csr_write(CSR_SECTOR_WIDTH, CSR_DAT_W'(sw_list[ph]));
            csr_write(CSR_MEDIUM_SPEED, CSR_DAT_W'(ms_list[ph]));
         end
         budget = PHASE_ITEMS;
         while (budget > 0) begin
            if ($urandom_range(0, 9) < 8) queue_approach(budget);
            else queue_noise(budget);
            // Keep the backlog short so that idling spreads over the whole phase.
            wait (pose_q.size() < 8);
            // Hold the receiver off while poses keep coming, so the block backs up.
            if (ph == 2 && budget < PHASE_ITEMS / 2 && stall_left == 0 && !stall_kick) begin
               @(posedge clock);
               stall_kick <= 1'b1;
               @(posedge clock);
               stall_kick <= 1'b0;
            end
         end
         drain();
      end

      $display("Sent %0d poses over five register settings and got %0d commands back.",
               sent_count, cmd_count);
      $display("Of those, %0d were spin commands and %0d reported arrival.",
               spin_count, arrive_count);
      if (fail_count == 0 && cmd_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d failures, %0d of them mismatches", fail_count, mismatch_count);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
